>>> rtl/fptq_pkg.sv
// Shared types, codes and constants for the feedback-paced transmit queue.
// No dependencies; every other file in rtl/ refers to this package.
`default_nettype none

package fptq_pkg;

    localparam int QUEUE_DEPTH_DEF   = 256;
    localparam int DURATION_BITS_DEF = 16;

    // Fixed field widths of the channels
    localparam int PKT_DUR_W   = 16;
    localparam int LIMIT_W     = 9;
    localparam int COUNT_OUT_W = 9;
    localparam int SLOW_W      = 8;
    localparam int SCALE_W     = 9;   // holds 10 + slowdown

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 9'd256;
    localparam logic [SLOW_W-1:0]  SLOW_MAX    = 8'd255;
    localparam logic [SLOW_W-1:0]  SLOW_UP     = 8'd2;
    localparam logic [SLOW_W-1:0]  SLOW_DOWN   = 8'd1;
    localparam logic [SCALE_W-1:0] TICK_SCALE  = 9'd10;

    // Operation codes of the input item
    localparam logic [1:0] OP_TICK     = 2'd0;
    localparam logic [1:0] OP_ENQUEUE  = 2'd1;
    localparam logic [1:0] OP_FEEDBACK = 2'd2;

    // Command queue between front and back
    localparam logic [1:0] CMDQ_EMPTY = 2'd0;
    localparam logic [1:0] CMDQ_FULL  = 2'd2;

    typedef enum logic [1:0] {
        CMD_TICK,
        CMD_ENQUEUE,
        CMD_FEEDBACK,
        CMD_IDLE
    } cmd_kind_t;

    typedef struct packed {
        logic [1:0]           operation;
        logic [PKT_DUR_W-1:0] pkt_duration;
        logic                 full_queue;
        logic                 full_rx;
        logic                 speed_up;
    } item_t;

    typedef struct packed {
        logic                   sent_valid;
        logic [PKT_DUR_W-1:0]   sent_duration;
        logic                   dropped;
        logic [COUNT_OUT_W-1:0] queue_count;
        logic [SLOW_W-1:0]      slowdown_level;
    } result_t;

    typedef struct packed {
        cmd_kind_t            kind;
        logic [PKT_DUR_W-1:0] duration;
        logic                 slow_inc;
        logic                 slow_dec;
    } cmd_t;

endpackage

`default_nettype wire

>>> rtl/feedback_paced_tx_queue.sv
// Top level of the feedback-paced transmit queue: front decoder, command queue, back end.
// Depends on fptq_pkg, fptq_front, fptq_cmd_queue and fptq_back.
//
// Channel   Dir   Handshake                     Payload
// item      in    item_valid / item_ready       fptq_pkg::item_t
// result    out   result_valid / result_ready   fptq_pkg::result_t
// cfg       in    cfg_we, no stall              cfg_wdata = queue_limit
//
// One item per clock sustained while results are taken; one result per item, registered
// through the command queue slot, then the back end and result register.
// The back end retires one command per cycle unless the result stalls: one FIFO memory
// write and one read per cycle and one duration multiply into the timer register.
// Reset needs no clearing pass; FIFO entries are read only after being written.
// A stalled result holds the back end; the two-entry command queue keeps
// item_ready high until it fills.
`default_nettype none

module feedback_paced_tx_queue #(
    parameter int QUEUE_DEPTH   = fptq_pkg::QUEUE_DEPTH_DEF,
    parameter int DURATION_BITS = fptq_pkg::DURATION_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         item_valid,
    output logic                         item_ready,
    input  fptq_pkg::item_t              item,
    output logic                         result_valid,
    input  logic                         result_ready,
    output fptq_pkg::result_t            result,
    input  logic                         cfg_we,
    input  logic [fptq_pkg::LIMIT_W-1:0] cfg_wdata
);

    logic           front_valid;
    logic           front_ready;
    fptq_pkg::cmd_t front_cmd;
    logic           back_valid;
    logic           back_ready;
    fptq_pkg::cmd_t back_cmd;

    fptq_front u_front (
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .cmd_valid  (front_valid),
        .cmd_ready  (front_ready),
        .cmd        (front_cmd)
    );

    fptq_cmd_queue u_cmd_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_data  (front_cmd),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready),
        .pop_data   (back_cmd)
    );

    fptq_back #(
        .QUEUE_DEPTH   (QUEUE_DEPTH),
        .DURATION_BITS (DURATION_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .cmd_valid    (back_valid),
        .cmd_ready    (back_ready),
        .cmd          (back_cmd),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

`default_nettype wire

>>> rtl/fptq_front.sv
// Front end: decodes an input item into a queue command.
// Depends on fptq_pkg (item_t, cmd_t, operation codes).
`default_nettype none

module fptq_front (
    input  logic            item_valid,
    output logic            item_ready,
    input  fptq_pkg::item_t item,
    output logic            cmd_valid,
    input  logic            cmd_ready,
    output fptq_pkg::cmd_t  cmd
);

    // Zero fields that do not belong to the operation
    always_comb
    begin
        cmd.duration = '0;
        cmd.slow_inc = 1'b0;
        cmd.slow_dec = 1'b0;
        unique case (item.operation)
            fptq_pkg::OP_TICK:
            begin
                cmd.kind = fptq_pkg::CMD_TICK;
            end
            fptq_pkg::OP_ENQUEUE:
            begin
                cmd.kind     = fptq_pkg::CMD_ENQUEUE;
                cmd.duration = item.pkt_duration;
            end
            fptq_pkg::OP_FEEDBACK:
            begin
                cmd.kind     = fptq_pkg::CMD_FEEDBACK;
                cmd.slow_inc = item.full_queue | item.full_rx;
                cmd.slow_dec = item.speed_up;
            end
            default:
            begin
                cmd.kind = fptq_pkg::CMD_IDLE;
            end
        endcase
    end

    assign cmd_valid  = item_valid;
    assign item_ready = cmd_ready;

endmodule

`default_nettype wire

>>> rtl/fptq_cmd_queue.sv
// Two-entry command queue that decouples the front end from the back end.
// Depends on fptq_pkg (cmd_t, queue fill codes).
`default_nettype none

module fptq_cmd_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  fptq_pkg::cmd_t push_data,
    output logic           pop_valid,
    input  logic           pop_ready,
    output fptq_pkg::cmd_t pop_data
);

    fptq_pkg::cmd_t slot_reg [2];
    logic           wr_ptr_reg;
    logic           wr_ptr_next;
    logic           rd_ptr_reg;
    logic           rd_ptr_next;
    logic [1:0]     count_reg;
    logic [1:0]     count_next;
    logic           push;
    logic           pop;

    assign push_ready = (count_reg != fptq_pkg::CMDQ_FULL);
    assign pop_valid  = (count_reg != fptq_pkg::CMDQ_EMPTY);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= fptq_pkg::CMDQ_EMPTY;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

>>> rtl/fptq_back.sv
// Back end: packet FIFO memory, sender timer, slowdown level and result register.
// Depends on fptq_pkg (cmd_t, result_t, constants).
`default_nettype none

module fptq_back #(
    parameter int QUEUE_DEPTH   = fptq_pkg::QUEUE_DEPTH_DEF,
    parameter int DURATION_BITS = fptq_pkg::DURATION_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [fptq_pkg::LIMIT_W-1:0]   cfg_wdata,
    input  logic                           cmd_valid,
    output logic                           cmd_ready,
    input  fptq_pkg::cmd_t                 cmd,
    output logic                           result_valid,
    input  logic                           result_ready,
    output fptq_pkg::result_t              result
);

    localparam int PTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int LIM_W     = fptq_pkg::LIMIT_W;
    localparam int CMP_W     = (CNT_W > LIM_W) ? CNT_W : LIM_W;
    localparam int SCL_W     = fptq_pkg::SCALE_W;
    localparam int SLW_W     = fptq_pkg::SLOW_W;
    localparam int TMR_W     = DURATION_BITS + SCL_W;
    localparam int DUR_OUT_W = fptq_pkg::PKT_DUR_W;
    localparam int CNT_OUT_W = fptq_pkg::COUNT_OUT_W;

    localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CMP_W-1:0] DEPTH_CMP = CMP_W'(QUEUE_DEPTH);
    localparam logic [TMR_W-1:0] TICK_STEP = TMR_W'(fptq_pkg::TICK_SCALE);

    // Packet FIFO, registered read
    logic [DURATION_BITS-1:0] mem [QUEUE_DEPTH];
    logic [DURATION_BITS-1:0] rd_data_reg;
    logic                     fwd_valid_reg;
    logic [DURATION_BITS-1:0] fwd_data_reg;

    logic [PTR_W-1:0]   head_ptr_reg;
    logic [PTR_W-1:0]   head_ptr_next;
    logic [PTR_W-1:0]   tail_ptr_reg;
    logic [PTR_W-1:0]   tail_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               busy_reg;
    logic               busy_next;
    logic [TMR_W-1:0]   timer_reg;
    logic [TMR_W-1:0]   timer_next;
    logic [SLW_W-1:0]   slow_reg;
    logic [SLW_W-1:0]   slow_next;
    logic [LIM_W-1:0]   limit_reg;
    logic               res_valid_reg;
    logic               res_valid_next;
    fptq_pkg::result_t  res_reg;
    fptq_pkg::result_t  res_next;

    logic                     fire;
    logic                     push;
    logic                     pop;
    logic                     send;
    logic                     drop;
    logic [DURATION_BITS-1:0] head_dur;
    logic [DURATION_BITS-1:0] cmd_dur;
    logic [DURATION_BITS-1:0] send_dur;
    logic [CMP_W-1:0]         limit_cmp;
    logic                     is_full;
    logic [TMR_W-1:0]         timer_dec;
    logic                     expire;
    logic [SCL_W-1:0]         scale;
    logic [SCL_W-1:0]         slow_add;
    logic [SLW_W-1:0]         slow_sat;
    logic [SLW_W-1:0]         slow_mid;

    assign cmd_ready = !res_valid_reg || result_ready;
    assign fire      = cmd_valid && cmd_ready;
    assign head_dur  = fwd_valid_reg ? fwd_data_reg : rd_data_reg;
    assign cmd_dur   = DURATION_BITS'(cmd.duration);
    assign limit_cmp = (CMP_W'(limit_reg) > DEPTH_CMP) ? DEPTH_CMP : CMP_W'(limit_reg);
    assign is_full   = (CMP_W'(count_reg) >= limit_cmp);

    // Timer holds duration*(10+slowdown); a tick takes one tenth-unit step of 10
    assign timer_dec = (timer_reg >= TICK_STEP) ? (timer_reg - TICK_STEP) : timer_reg;
    assign expire    = (timer_dec < TICK_STEP);
    assign scale     = fptq_pkg::TICK_SCALE + SCL_W'(slow_reg);

    assign slow_add = SCL_W'(slow_reg) + SCL_W'(fptq_pkg::SLOW_UP);
    assign slow_sat = (slow_add > SCL_W'(fptq_pkg::SLOW_MAX)) ? fptq_pkg::SLOW_MAX
                                                              : SLW_W'(slow_add);
    assign slow_mid = cmd.slow_inc ? slow_sat : slow_reg;

    always_comb
    begin
        push      = 1'b0;
        pop       = 1'b0;
        send      = 1'b0;
        drop      = 1'b0;
        send_dur  = head_dur;
        busy_next = busy_reg;
        timer_next = timer_reg;
        slow_next = slow_reg;
        if (fire)
        begin
            unique case (cmd.kind)
                fptq_pkg::CMD_TICK:
                begin
                    if (busy_reg)
                    begin
                        timer_next = timer_dec;
                        if (expire)
                        begin
                            if (count_reg != '0)
                            begin
                                send = 1'b1;
                                pop  = 1'b1;
                            end
                            else
                            begin
                                busy_next = 1'b0;
                            end
                        end
                    end
                end
                fptq_pkg::CMD_ENQUEUE:
                begin
                    // Drop if full; idle sender implies empty FIFO: send directly
                    if (is_full)
                    begin
                        drop = 1'b1;
                    end
                    else if (busy_reg)
                    begin
                        push = 1'b1;
                    end
                    else
                    begin
                        send     = 1'b1;
                        send_dur = cmd_dur;
                    end
                end
                fptq_pkg::CMD_FEEDBACK:
                begin
                    if (cmd.slow_dec && (slow_mid != '0))
                    begin
                        slow_next = slow_mid - fptq_pkg::SLOW_DOWN;
                    end
                    else
                    begin
                        slow_next = slow_mid;
                    end
                end
                default:
                begin
                end
            endcase
        end
        if (send)
        begin
            busy_next  = 1'b1;
            timer_next = TMR_W'(send_dur) * TMR_W'(scale);
        end
    end

    always_comb
    begin
        head_ptr_next = head_ptr_reg;
        tail_ptr_next = tail_ptr_reg;
        count_next    = count_reg;
        if (pop)
        begin
            head_ptr_next = (head_ptr_reg == PTR_LAST) ? '0 : head_ptr_reg + PTR_W'(1);
            count_next    = count_reg - CNT_W'(1);
        end
        if (push)
        begin
            tail_ptr_next = (tail_ptr_reg == PTR_LAST) ? '0 : tail_ptr_reg + PTR_W'(1);
            count_next    = count_reg + CNT_W'(1);
        end
    end

    always_comb
    begin
        res_next.sent_valid     = send;
        res_next.sent_duration  = send ? DUR_OUT_W'(send_dur) : '0;
        res_next.dropped        = drop;
        res_next.queue_count    = CNT_OUT_W'(count_next);
        res_next.slowdown_level = slow_next;
        if (fire)
        begin
            res_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_ptr_reg  <= '0;
            tail_ptr_reg  <= '0;
            count_reg     <= '0;
            busy_reg      <= 1'b0;
            timer_reg     <= '0;
            slow_reg      <= '0;
            limit_reg     <= fptq_pkg::LIMIT_RESET;
            res_valid_reg <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            head_ptr_reg  <= head_ptr_next;
            tail_ptr_reg  <= tail_ptr_next;
            count_reg     <= count_next;
            busy_reg      <= busy_next;
            timer_reg     <= timer_next;
            slow_reg      <= slow_next;
            res_valid_reg <= res_valid_next;
            // Forward a write that lands on the entry being read
            fwd_valid_reg <= push && (tail_ptr_reg == head_ptr_next);
            if (cfg_we)
            begin
                limit_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[tail_ptr_reg] <= cmd_dur;
        end
        rd_data_reg  <= mem[head_ptr_next];
        fwd_data_reg <= cmd_dur;
        if (fire)
        begin
            res_reg <= res_next;
        end
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

endmodule

`default_nettype wire

>>> rtl/fptq_checker.sv
// Port-level checks on the transmit queue, attached to the top level by bind.
// Depends on fptq_pkg (result_t) and feedback_paced_tx_queue.
`default_nettype none

module fptq_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              item_ready,
    input logic              result_valid,
    input logic              result_ready,
    input fptq_pkg::result_t result
);

    // Hold a stalled result transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    // A dropped arrival never sends
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.dropped |-> !result.sent_valid)
        else $error("drop and send in one result");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.sent_valid |-> result.sent_duration == '0)
        else $error("duration reported without a send");

    // The command queue fills only behind a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> item_ready)
        else $error("input stalled with an empty output");

endmodule

bind feedback_paced_tx_queue fptq_checker u_fptq_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_ready   (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);

`default_nettype wire
